[hdl/websocket_frame_deframer_defines.svh]
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is asserted
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("deframer check failed");
// clocked check that also holds during reset
`define WSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("deframer check failed");
`else
`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hdl/wsd_pkg.sv]
// package with opcodes, result kinds, length codes, byte sizes and parser phases for the deframer
`timescale 1ns / 1ps

package wsd_pkg;

  // frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // result kinds
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_BIN  = 2'd1;
  localparam logic [1:0] KIND_PING = 2'd2;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length and mask key sizes in bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // parser phases
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAY
  } phase_e;

endpackage

[hdl/wsd_rx_if.sv]
// byte stream channel into the deframer
`timescale 1ns / 1ps

interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/wsd_res_if.sv]
// result channel out of the deframer
`timescale 1ns / 1ps

interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic [1:0] kind;
  logic       message_last;
  logic       discard_previous;
  logic       close_event;

  modport source (
    output valid, output data_byte, output has_data, output kind,
    output message_last, output discard_previous, output close_event,
    input ready
  );
  modport sink (
    input valid, input data_byte, input has_data, input kind,
    input message_last, input discard_previous, input close_event,
    output ready
  );
endinterface

[hdl/websocket_frame_deframer.sv]
// websocket frame deframer: header parser, payload unmasking and result register
// Usage: received bytes arrive one per transaction on rx_i. Each byte either
// advances the header parser (flags and opcode, 7/16/64-bit length, mask key)
// or is a payload byte, which is unmasked and given on res_o together with
// the message kind, an end-of-message mark and a discard flag. Ping payload
// comes out with kind ping, a completed close frame gives one close_event
// transaction, after which every further byte is taken and dropped.
// Throughput: one byte per cycle while rx_i.ready is high. A byte is parsed in the
// cycle it is taken and its result sits in the result register from the next
// cycle on; the 64-bit length down-counter and its compare set the path.
// Skipped payload and bytes after close give no transaction; header bytes give
// none either, except the last header byte of an empty ping, close, message end
// or new message that abandons unfinished bytes.
// Stall: rx_i.ready is high while the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds back at most one
// result and the input stops only while that result waits.
// Reset: rst_ni clears the parser to wait for a first header byte, with no
// open message, text as message type and the link open; no result is valid.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_rx_if.sink    rx_i,
  wsd_res_if.source res_o
);

  // result register contents
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [1:0] kind;
    logic       message_last;
    logic       discard_previous;
    logic       close_event;
  } res_t;

  // parser state
  wsd_pkg::phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] remaining_q, remaining_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [1:0]  mask_index_q, mask_index_d;
  logic        msg_open_q, msg_open_d;
  logic        msg_binary_q, msg_binary_d;
  logic        msg_has_bytes_q, msg_has_bytes_d;
  logic        closed_q, closed_d;

  // result register
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;
  logic emit;

  // decode
  logic        rx_take;
  logic        work;
  logic [7:0]  b;
  logic [6:0]  len7;
  logic [3:0]  ext_dec;
  logic [63:0] ext_shift;
  logic [31:0] key_shift;
  logic        hdr_fire;
  logic [63:0] hdr_rem;
  logic        pay_last;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        is_data_op;
  logic        is_new_msg;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_take    = rx_i.valid && rx_i.ready;
  assign work       = rx_take && !closed_q;
  assign b          = rx_i.rx_byte;
  assign len7       = b[6:0];
  assign ext_dec    = ext_left_q - 4'd1;
  assign ext_shift  = {remaining_q[55:0], b};
  assign key_shift  = {mask_key_q[23:0], b};
  assign pay_last   = (remaining_q == 64'd1);
  assign key_byte   = mask_key_q[{2'd3 - mask_index_q, 3'd0} +: 8];
  assign plain      = b ^ key_byte;
  assign is_data_op = (opcode_q == wsd_pkg::OP_CONT) || (opcode_q == wsd_pkg::OP_TEXT) ||
                      (opcode_q == wsd_pkg::OP_BIN);
  assign is_new_msg = (opcode_q == wsd_pkg::OP_TEXT) || (opcode_q == wsd_pkg::OP_BIN);

  // end of header detection and the length it leaves
  always_comb begin
    hdr_fire = 1'b0;
    hdr_rem  = remaining_q;
    unique case (phase_q)
      wsd_pkg::PH_HDR1: begin
        hdr_fire = (len7 != wsd_pkg::LEN_EXT16) && (len7 != wsd_pkg::LEN_EXT64) && !b[7];
        hdr_rem  = {57'd0, len7};
      end
      wsd_pkg::PH_EXT: begin
        hdr_fire = (ext_dec == 4'd0) && !masked_q;
        hdr_rem  = ext_shift;
      end
      wsd_pkg::PH_KEY: begin
        hdr_fire = (ext_dec == 4'd0);
      end
      default: ;
    endcase
  end

  // next parser state
  always_comb begin
    phase_d         = phase_q;
    fin_d           = fin_q;
    opcode_d        = opcode_q;
    masked_d        = masked_q;
    ext_left_d      = ext_left_q;
    remaining_d     = remaining_q;
    mask_key_d      = mask_key_q;
    mask_index_d    = mask_index_q;
    msg_open_d      = msg_open_q;
    msg_binary_d    = msg_binary_q;
    msg_has_bytes_d = msg_has_bytes_q;
    closed_d        = closed_q;
    if (work) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR0: begin
          fin_d        = b[7];
          opcode_d     = b[3:0];
          masked_d     = 1'b0;
          mask_key_d   = 32'd0;
          mask_index_d = 2'd0;
          ext_left_d   = 4'd0;
          remaining_d  = 64'd0;
          phase_d      = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          masked_d = b[7];
          if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
            remaining_d = 64'd0;
            ext_left_d  = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                        : wsd_pkg::EXT64_BYTES;
            phase_d     = wsd_pkg::PH_EXT;
          end else begin
            remaining_d = hdr_rem;
            if (b[7]) begin
              ext_left_d = wsd_pkg::KEY_BYTES;
              phase_d    = wsd_pkg::PH_KEY;
            end
          end
        end
        wsd_pkg::PH_EXT: begin
          remaining_d = ext_shift;
          ext_left_d  = ext_dec;
          if (ext_dec == 4'd0 && masked_q) begin
            ext_left_d = wsd_pkg::KEY_BYTES;
            phase_d    = wsd_pkg::PH_KEY;
          end
        end
        wsd_pkg::PH_KEY: begin
          mask_key_d = key_shift;
          ext_left_d = ext_dec;
        end
        wsd_pkg::PH_PAY: begin
          mask_index_d = mask_index_q + 2'd1;
          remaining_d  = remaining_q - 64'd1;
          if (pay_last) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
          if (is_data_op) begin
            if (is_new_msg) begin
              opcode_d = wsd_pkg::OP_CONT;
            end
            msg_has_bytes_d = 1'b1;
            msg_open_d      = 1'b1;
            if (pay_last && fin_q) begin
              msg_open_d      = 1'b0;
              msg_has_bytes_d = 1'b0;
            end
          end else if (opcode_q == wsd_pkg::OP_CLOSE && pay_last) begin
            closed_d = 1'b1;
          end
        end
        default: ;
      endcase

      // end of header actions
      if (hdr_fire) begin
        if (hdr_rem != 64'd0) begin
          if (is_new_msg) begin
            msg_binary_d = (opcode_q == wsd_pkg::OP_BIN);
            msg_open_d   = 1'b1;
          end
          phase_d = wsd_pkg::PH_PAY;
        end else begin
          phase_d = wsd_pkg::PH_HDR0;
          if (opcode_q == wsd_pkg::OP_CONT) begin
            if (fin_q) begin
              msg_open_d      = 1'b0;
              msg_has_bytes_d = 1'b0;
            end
          end else if (is_new_msg) begin
            msg_binary_d    = (opcode_q == wsd_pkg::OP_BIN);
            msg_has_bytes_d = 1'b0;
            msg_open_d      = !fin_q;
          end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
            closed_d = 1'b1;
          end
        end
      end
    end
  end

  // result for the byte being taken
  always_comb begin
    emit  = 1'b0;
    res_d = '0;
    if (work) begin
      if (hdr_fire && hdr_rem == 64'd0) begin
        priority if (opcode_q == wsd_pkg::OP_CONT) begin
          emit               = fin_q && msg_has_bytes_q;
          res_d.kind         = {1'b0, msg_binary_q};
          res_d.message_last = 1'b1;
        end else if (is_new_msg) begin
          emit                   = msg_has_bytes_q;
          res_d.kind             = (opcode_q == wsd_pkg::OP_BIN) ? wsd_pkg::KIND_BIN
                                                                 : wsd_pkg::KIND_TEXT;
          res_d.discard_previous = 1'b1;
        end else if (opcode_q == wsd_pkg::OP_PING) begin
          emit               = 1'b1;
          res_d.kind         = wsd_pkg::KIND_PING;
          res_d.message_last = 1'b1;
        end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
          emit              = 1'b1;
          res_d.close_event = 1'b1;
        end else begin
          emit = 1'b0;
        end
      end else if (phase_q == wsd_pkg::PH_PAY) begin
        priority if (is_data_op) begin
          emit                   = 1'b1;
          res_d.data_byte        = plain;
          res_d.has_data         = 1'b1;
          res_d.kind             = {1'b0, msg_binary_q};
          res_d.message_last     = pay_last && fin_q;
          res_d.discard_previous = is_new_msg && msg_has_bytes_q;
        end else if (opcode_q == wsd_pkg::OP_PING) begin
          emit               = 1'b1;
          res_d.data_byte    = plain;
          res_d.has_data     = 1'b1;
          res_d.kind         = wsd_pkg::KIND_PING;
          res_d.message_last = pay_last;
        end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
          emit              = pay_last;
          res_d.close_event = 1'b1;
        end else begin
          emit = 1'b0;
        end
      end
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= wsd_pkg::PH_HDR0;
      fin_q           <= 1'b0;
      opcode_q        <= wsd_pkg::OP_CONT;
      masked_q        <= 1'b0;
      ext_left_q      <= 4'd0;
      remaining_q     <= 64'd0;
      mask_key_q      <= 32'd0;
      mask_index_q    <= 2'd0;
      msg_open_q      <= 1'b0;
      msg_binary_q    <= 1'b0;
      msg_has_bytes_q <= 1'b0;
      closed_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      fin_q           <= fin_d;
      opcode_q        <= opcode_d;
      masked_q        <= masked_d;
      ext_left_q      <= ext_left_d;
      remaining_q     <= remaining_d;
      mask_key_q      <= mask_key_d;
      mask_index_q    <= mask_index_d;
      msg_open_q      <= msg_open_d;
      msg_binary_q    <= msg_binary_d;
      msg_has_bytes_q <= msg_has_bytes_d;
      closed_q        <= closed_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.data_byte        = res_q.data_byte;
  assign res_o.has_data         = res_q.has_data;
  assign res_o.kind             = res_q.kind;
  assign res_o.message_last     = res_q.message_last;
  assign res_o.discard_previous = res_q.discard_previous;
  assign res_o.close_event      = res_q.close_event;

  // checks
  `WSD_ASSERT(a_bytes_imply_open, clk_i, rst_ni, msg_has_bytes_q |-> msg_open_q)
  `WSD_ASSERT(a_closed_sticky, clk_i, rst_ni, closed_q |=> closed_q)
  `WSD_ASSERT(a_payload_nonzero, clk_i, rst_ni,
    (phase_q == wsd_pkg::PH_PAY) |-> (remaining_q != 64'd0))
  `WSD_ASSERT(a_no_emit_closed, clk_i, rst_ni, closed_q |-> !emit)
  `WSD_ASSERT(a_close_no_data, clk_i, rst_ni,
    (out_valid_q && res_q.close_event) |-> (!res_q.has_data && !res_q.message_last))
  `WSD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_q)

endmodule
